@@ rtl/core/spimbt_pkg.sv @@
// Shared types and constants for the SPI master byte transfer unit.
package spimbt_pkg;

  localparam int WORD_BITS_DEFAULT = 8;
  localparam int QUEUE_DEPTH       = 2;
  localparam int HALF_W            = 16;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_SPI_MODE  = 2'd0,
    REG_LSB_FIRST = 2'd1,
    REG_HALF_PER  = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]        spi_mode;
    logic              lsb_first;
    logic [HALF_W-1:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       miso;
  } item_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
  } res_t;

endpackage

@@ rtl/core/spimbt_regs.sv @@
// APB configuration registers.
module spimbt_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output spimbt_pkg::cfg_t    cfg
);
  import spimbt_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spi_mode          <= 2'd0;
      cfg.lsb_first         <= 1'b0;
      cfg.half_period_ticks <= HALF_W'(1);
    end else if (wr_en) begin
      unique case (idx)
        REG_SPI_MODE:  cfg.spi_mode          <= pwdata[1:0];
        REG_LSB_FIRST: cfg.lsb_first         <= pwdata[0];
        REG_HALF_PER:  cfg.half_period_ticks <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPI_MODE:  prdata = 32'(cfg.spi_mode);
      REG_LSB_FIRST: prdata = 32'(cfg.lsb_first);
      REG_HALF_PER:  prdata = 32'(cfg.half_period_ticks);
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/core/spimbt_front.sv @@
// Front end: takes stream transfers, classifies them and feeds the queue.
module spimbt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,
  input  logic                s_tuser,
  output logic                push,
  output spimbt_pkg::item_t   push_item,
  input  logic                q_ready
);
  import spimbt_pkg::*;

  logic  hold_valid;
  item_t hold_item;

  assign push      = hold_valid;
  assign push_item = hold_item;
  assign s_tready  = !hold_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tready) begin
      hold_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold_item.kind    <= s_tuser ? KIND_START : KIND_TICK;
      hold_item.tx_byte <= s_tdata[7:0];
      hold_item.miso    <= s_tdata[8];
    end
  end

endmodule

@@ rtl/core/spimbt_queue.sv @@
// Short FIFO between the front end and the bit engine.
module spimbt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  spimbt_pkg::item_t   push_item,
  output logic                not_full,
  input  logic                pop,
  output logic                not_empty,
  output spimbt_pkg::item_t   head
);
  import spimbt_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign not_full  = count < CntW'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/core/spimbt_back.sv @@
// Bit engine: advances the SPI transfer by one tick per queued item.
module spimbt_back #(
  parameter int WORD_BITS = spimbt_pkg::WORD_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  spimbt_pkg::cfg_t    cfg,
  input  logic                q_valid,
  input  spimbt_pkg::item_t   q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output spimbt_pkg::res_t    m_res
);
  import spimbt_pkg::*;

  localparam int BitW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] tx_shift, tx_shift_next;
  logic [WORD_BITS-1:0] rx_shift, rx_shift_next;
  logic [BitW-1:0]      bit_index, bit_index_next;
  logic                 second_half, second_half_next;
  logic [HALF_W-1:0]    tick_count, tick_count_next;
  logic                 active, active_next;
  logic                 mosi_level, mosi_level_next;
  res_t                 res_next;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    logic              load;
    logic              cpol;
    logic              cpha;
    logic [HALF_W-1:0] half;
    logic [HALF_W:0]   tc_inc;
    logic              sample;
    cpol   = cfg.spi_mode[1];
    cpha   = cfg.spi_mode[0];
    half   = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
    load   = !active && (q_item.kind == KIND_START);

    tx_shift_next    = load ? WORD_BITS'(q_item.tx_byte) : tx_shift;
    rx_shift_next    = load ? '0 : rx_shift;
    bit_index_next   = load ? '0 : bit_index;
    second_half_next = load ? 1'b0 : second_half;
    tick_count_next  = load ? '0 : tick_count;
    active_next      = active || load;
    mosi_level_next  = mosi_level;

    res_next = '0;
    res_next.sck = cpol;
    tc_inc = '0;
    sample = 1'b0;

    if (active_next) begin
      res_next.busy_res = 1'b1;
      if (!second_half_next) begin
        if (tick_count_next == '0) begin
          if (cfg.lsb_first) begin
            mosi_level_next = tx_shift_next[0];
            tx_shift_next   = tx_shift_next >> 1;
          end else begin
            mosi_level_next = tx_shift_next[WORD_BITS-1];
            tx_shift_next   = tx_shift_next << 1;
          end
        end
        // CPHA=0 samples on the leading tick, CPHA=1 on the last active tick
        sample = cpha ? (tick_count_next == half - 1'b1) : (tick_count_next == '0);
        if (sample && q_item.miso) begin
          rx_shift_next[bit_index_next] = 1'b1;
        end
        res_next.sck = !cpol;
      end
      res_next.mosi = mosi_level_next;

      tc_inc = {1'b0, tick_count_next} + 1'b1;
      if (tc_inc >= {1'b0, half}) begin
        tick_count_next = '0;
        if (!second_half_next) begin
          second_half_next = 1'b1;
        end else begin
          second_half_next = 1'b0;
          if (bit_index_next == BitW'(WORD_BITS - 1)) begin
            res_next.done_res = 1'b1;
            res_next.rx_byte  = 8'(rx_shift_next);
            active_next       = 1'b0;
            bit_index_next    = '0;
            mosi_level_next   = 1'b1;
          end else begin
            bit_index_next = bit_index_next + 1'b1;
          end
        end
      end else begin
        tick_count_next = tc_inc[HALF_W-1:0];
      end
    end else begin
      res_next.mosi = mosi_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift    <= '0;
      rx_shift    <= '0;
      bit_index   <= '0;
      second_half <= 1'b0;
      tick_count  <= '0;
      active      <= 1'b0;
      mosi_level  <= 1'b1;
      m_tvalid    <= 1'b0;
    end else begin
      if (q_pop) begin
        tx_shift    <= tx_shift_next;
        rx_shift    <= rx_shift_next;
        bit_index   <= bit_index_next;
        second_half <= second_half_next;
        tick_count  <= tick_count_next;
        active      <= active_next;
        mosi_level  <= mosi_level_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_res <= res_next;
    end
  end

endmodule

@@ rtl/core/spi_master_byte_transfer_unit.sv @@
// SPI master (modes 0 to 3) that shifts one word per transfer, one tick per stream transfer.
// Each input transfer is one time tick and yields exactly one output transfer with the
// SCK and MOSI levels, busy, done (on tlast) and the received byte. The unit sustains one
// tick per clock cycle while the output is not stalled: the bit engine updates its shift
// registers, bit and tick counters with a 17-bit add and compare for the tick counter. A
// result passes through three registers: the input lands in the front register when it is
// taken, moves into the two-entry queue and then into the output register. Either side may
// stall independently. Received bits land LSB-first; MOSI idles high. Configure over APB
// only while no ticks are in flight.
module spi_master_byte_transfer_unit #(
  parameter int WORD_BITS = spimbt_pkg::WORD_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] miso, [15:9] zero
  input  logic        s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] sck, [1] mosi, [2] busy_res, [10:3] rx_byte, [15:11] zero
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import spimbt_pkg::*;

  cfg_t  cfg;
  logic  push;
  item_t push_item;
  logic  q_not_full;
  logic  q_not_empty;
  logic  q_pop;
  item_t q_head;
  res_t  m_res;

  spimbt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spimbt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_not_full)
  );

  spimbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  spimbt_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_not_empty),
    .q_item   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {5'd0, m_res.rx_byte, m_res.busy_res, m_res.mosi, m_res.sck};
  assign m_tlast = m_res.done_res;

  // done only ever closes a transfer that is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[2])
    else $error("done without busy");

  // MOSI idles high between transfers
  a_idle_mosi: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[1])
    else $error("MOSI low while idle");

  // no result is presented straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
